### design/bba_pkg.sv
package bba_pkg;

  // Map geometry
  localparam int NUM_BLOCKS = 2048;
  localparam int WORD_W     = 64;
  localparam int NUM_WORDS  = NUM_BLOCKS / WORD_W;
  localparam int ROW_W      = $clog2(NUM_WORDS);
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int BLK_W      = 11;
  localparam int CFG_W      = 12;
  localparam int CFG_IDX_W  = 2;

  // Register reset values
  localparam logic [CFG_W-1:0] DATA_START_RST  = CFG_W'(39);
  localparam logic [CFG_W-1:0] BLOCK_COUNT_RST = CFG_W'(2048);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DATA_START  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_FORMAT = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    opcode_t          opcode;
    logic [BLK_W-1:0] block_number;
  } in_item_t;

  typedef struct packed {
    status_t          status;
    logic [BLK_W-1:0] granted_block;
  } out_item_t;

  // Map row write port
  typedef struct packed {
    logic              en;
    logic [ROW_W-1:0]  addr;
    logic [WORD_W-1:0] data;
  } map_wr_t;

endpackage

### design/bba_map_ram.sv
module bba_map_ram
  import bba_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  map_wr_t           wr,
  input  logic [ROW_W-1:0]  raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] row_valid_r;
  logic [WORD_W-1:0]    rd_word_r;
  logic                 rd_valid_r;

  // Row storage, registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_word_r <= mem[raddr];
  end

  // Per-row valid bits: a row never written since reset reads as all free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      rd_valid_r  <= 1'b0;
    end else begin
      if (wr.en) begin
        row_valid_r[wr.addr] <= 1'b1;
      end
      rd_valid_r <= row_valid_r[raddr];
    end
  end

  assign rdata = rd_valid_r ? rd_word_r : '0;

endmodule

### design/bba_row_find.sv
module bba_row_find
  import bba_pkg::*;
(
  input  logic [WORD_W-1:0] cand,
  output logic              found,
  output logic [BIT_W-1:0]  idx
);

  // Lowest set bit of the candidate word
  always_comb begin
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        idx = BIT_W'(i);
      end
    end
  end

  assign found = |cand;

endmodule

### design/bitmap_block_allocator.sv
// First-fit block allocator over a 2048-bit used map held as 32 rows of 64 bits.
// Allocate: scans map rows in order from the data_start row to the first free bit; FULL if start >= bound.
// Free: read-modify-write of one row; out-of-range free and unused opcode answer without a map access.
// Format: writes every map row in turn, one row per cycle. One item at a time; result registered.
// Reset (rst_n low, synchronous) clears the map at once through per-row valid bits
// and sets data_start to 39 and block_count to 2048.
module bitmap_block_allocator
  import bba_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FREE,
    S_FMT
  } state_t;

  state_t             state_r, state_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [BLK_W-1:0]   blk_r, blk_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;
  logic [CFG_W-1:0]   data_start_r, block_count_r;

  map_wr_t            map_wr;
  logic [ROW_W-1:0]   raddr;
  logic [WORD_W-1:0]  rdata;

  logic [CFG_W-1:0]   lim;
  logic [BLK_W-1:0]   last_blk;
  logic [ROW_W-1:0]   start_row, end_row;
  logic [CFG_W-1:0]   fmt_n;
  logic [WORD_W-1:0]  lo_mask, hi_mask, cand, fmt_mask, blk_bit;
  logic               hit;
  logic [BIT_W-1:0]   hit_idx;
  logic               accept, out_free;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_start_r  <= DATA_START_RST;
      block_count_r <= BLOCK_COUNT_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_DATA_START) begin
        data_start_r <= cfg_wdata;
      end else if (cfg_index == REG_BLOCK_COUNT) begin
        block_count_r <= cfg_wdata;
      end
    end
  end

  // Scan bounds
  assign lim       = (block_count_r > CFG_W'(NUM_BLOCKS)) ? CFG_W'(NUM_BLOCKS)
                                                          : block_count_r;
  assign last_blk  = BLK_W'(lim - CFG_W'(1));
  assign start_row = data_start_r[BIT_W +: ROW_W];
  assign end_row   = last_blk[BIT_W +: ROW_W];
  assign fmt_n     = (data_start_r > CFG_W'(NUM_BLOCKS)) ? CFG_W'(NUM_BLOCKS)
                                                         : data_start_r;

  // Candidate free bits of the current row within [data_start, lim)
  assign lo_mask = (row_r == start_row) ? ({WORD_W{1'b1}} << data_start_r[BIT_W-1:0])
                                        : {WORD_W{1'b1}};
  assign hi_mask = (row_r == end_row)
                   ? ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - last_blk[BIT_W-1:0]))
                   : {WORD_W{1'b1}};
  assign cand    = ~rdata & lo_mask & hi_mask;

  // Format pattern of the current row
  always_comb begin
    if (fmt_n[CFG_W-1:BIT_W] > (CFG_W - BIT_W)'(row_r)) begin
      fmt_mask = {WORD_W{1'b1}};
    end else if (fmt_n[CFG_W-1:BIT_W] == (CFG_W - BIT_W)'(row_r)) begin
      fmt_mask = ~({WORD_W{1'b1}} << fmt_n[BIT_W-1:0]);
    end else begin
      fmt_mask = '0;
    end
  end

  assign blk_bit = WORD_W'(1) << blk_r[BIT_W-1:0];

  bba_map_ram u_map (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (map_wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  bba_row_find u_find (
    .cand  (cand),
    .found (hit),
    .idx   (hit_idx)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    blk_nxt       = blk_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    raddr         = row_r;
    map_wr        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_data.opcode)
            OP_ALLOC: begin
              if (data_start_r < lim) begin
                raddr     = start_row;
                row_nxt   = start_row;
                state_nxt = S_SCAN;
              end else begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{status: ST_FULL, granted_block: '0};
              end
            end
            OP_FREE: begin
              if ({1'b0, in_data.block_number} < lim) begin
                raddr     = in_data.block_number[BIT_W +: ROW_W];
                row_nxt   = in_data.block_number[BIT_W +: ROW_W];
                blk_nxt   = in_data.block_number;
                state_nxt = S_FREE;
              end else begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{status: ST_RANGE, granted_block: '0};
              end
            end
            OP_FORMAT: begin
              row_nxt   = '0;
              state_nxt = S_FMT;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{status: ST_OK, granted_block: '0};
            end
          endcase
        end
      end

      S_SCAN: begin
        if (hit) begin
          map_wr        = '{en: 1'b1, addr: row_r,
                            data: rdata | (WORD_W'(1) << hit_idx)};
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: ST_OK, granted_block: {row_r, hit_idx}};
          state_nxt     = S_IDLE;
        end else if (row_r == end_row) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: ST_FULL, granted_block: '0};
          state_nxt     = S_IDLE;
        end else begin
          raddr   = row_r + ROW_W'(1);
          row_nxt = row_r + ROW_W'(1);
        end
      end

      S_FREE: begin
        map_wr        = '{en: 1'b1, addr: row_r, data: rdata & ~blk_bit};
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{status: ST_OK, granted_block: '0};
        state_nxt     = S_IDLE;
      end

      S_FMT: begin
        map_wr = '{en: 1'b1, addr: row_r, data: fmt_mask};
        if (row_r == ROW_W'(NUM_WORDS - 1)) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: ST_OK, granted_block: '0};
          state_nxt     = S_IDLE;
        end else begin
          row_nxt = row_r + ROW_W'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    row_r      <= row_nxt;
    blk_r      <= blk_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
